[rtl/pms_pkg.sv]
`default_nettype none
package pms_pkg;

  localparam int NUM_OPS = 8;
  localparam int OP_W    = 6;
  localparam int IDX_W   = (NUM_OPS > 1) ? $clog2(NUM_OPS) : 1;
  localparam int CNT_W   = $clog2(NUM_OPS + 1);
  localparam int SUM_W   = 16 + $clog2(NUM_OPS);

  localparam logic [15:0] Q_ONE      = 16'd4096;
  localparam logic [15:0] P_INIT     = 16'(65536 / NUM_OPS);
  localparam logic [13:0] PMIN_RST   = 14'd3277;
  localparam logic [15:0] ALPHA_RST  = 16'd19661;

  // register indexes
  localparam logic [1:0] REG_PMIN  = 2'd0;
  localparam logic [1:0] REG_ALPHA = 2'd1;
  localparam logic [1:0] REG_MODE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROUL,
    ST_QUPD,
    ST_SUM,
    ST_DIVST,
    ST_DIVRUN,
    ST_PWR,
    ST_LEAD,
    ST_OUT
  } pms_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic roul_step;
    logic qupd;
    logic sum_step;
    logic div_start;
    logic div_step;
    logic pwr;
    logic lead_init;
    logic lead_step;
    logic lead_fast;
    logic commit;
    logic clr_idx;
  } pms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_reward;
    logic op_valid;
    logic untried_phase;
    logic scan_found;
    logic scan_last;
    logic roul_done;
    logic idx_last;
    logic div_done;
    logic lead_rescan;
  } pms_sts_t;

endpackage
`default_nettype wire

[rtl/pms_ctrl.sv]
`default_nettype none
module pms_ctrl
  import pms_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire pms_sts_t sts,
  output pms_cmd_t      cmd
);

  pms_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // decide path, then scan for an untried operator
        if (sts.is_reward) begin
          state_nxt = sts.op_valid ? ST_QUPD : ST_OUT;
        end else if (sts.untried_phase) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_found) begin
            state_nxt = ST_OUT;
          end else if (sts.scan_last) begin
            cmd.clr_idx = 1'b1;
            state_nxt = ST_ROUL;
          end
        end else begin
          cmd.clr_idx = 1'b1;
          state_nxt = ST_ROUL;
        end
      end
      ST_ROUL: begin
        cmd.roul_step = 1'b1;
        if (sts.roul_done) state_nxt = ST_OUT;
      end
      ST_QUPD: begin
        cmd.qupd    = 1'b1;
        cmd.clr_idx = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.idx_last) begin
          cmd.clr_idx = 1'b1;
          state_nxt = ST_DIVST;
        end
      end
      ST_DIVST: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIVRUN;
      end
      ST_DIVRUN: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_PWR;
      end
      ST_PWR: begin
        cmd.pwr = 1'b1;
        if (sts.idx_last) begin
          cmd.clr_idx = 1'b1;
          if (sts.lead_rescan) begin
            cmd.lead_init = 1'b1;
            state_nxt = ST_LEAD;
          end else begin
            cmd.lead_fast = 1'b1;
            cmd.commit = 1'b1;
            state_nxt = ST_OUT;
          end
        end else begin
          state_nxt = ST_DIVST;
        end
      end
      ST_LEAD: begin
        cmd.lead_step = 1'b1;
        if (sts.idx_last) begin
          cmd.commit = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/pms_dp.sv]
`default_nettype none
module pms_dp
  import pms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pms_cmd_t    cmd,
  output pms_sts_t         sts,
  input  wire logic        in_action,
  input  wire logic [5:0]  in_op_index,
  input  wire logic [15:0] in_reward_value,
  input  wire logic [15:0] in_random_draw,
  input  wire logic [13:0] pmin,
  input  wire logic [15:0] alpha,
  input  wire logic        mode,
  output logic [5:0]       out_chosen_op,
  output logic             out_from_untried,
  output logic [5:0]       out_leader_op,
  output logic             out_was_exploit
);

  logic [15:0]      q_r [NUM_OPS];
  logic [15:0]      p_r [NUM_OPS];
  logic [NUM_OPS-1:0] tried_r;
  logic [31:0]      rcnt_r, xpl_r, xpr_r;
  logic [OP_W-1:0]  lead_r;
  logic [15:0]      lq_r;

  logic             act_r;
  logic [OP_W-1:0]  op_r;
  logic [15:0]      rew_r, draw_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      cum_r;
  logic [SUM_W-1:0] sum_r;
  logic [OP_W-1:0]  chosen_r;
  logic             untried_r, exploit_r;
  logic [OP_W-1:0]  nlead_r;
  logic [15:0]      nlq_r;

  // divider: quotient = span*q / sum, restoring, one bit per cycle
  localparam int NUM_W = 17 + 16;
  localparam int DC_W  = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] dnum_r, dquo_r;
  logic [SUM_W:0]   drem_r;
  logic [DC_W-1:0]  dcnt_r;

  logic [IDX_W-1:0] op_idx;
  logic             last_idx;
  logic [16:0]      span;
  logic [19:0]      ftot;
  logic [15:0]      qop, diff;
  logic [31:0]      prod;
  logic [15:0]      qnew;
  logic [SUM_W:0]   rtry;
  logic [17:0]      pfull;
  logic [31:0]      cum_n;
  logic [IDX_W-1:0] start_idx;
  logic [15:0]      sel_q;

  assign op_idx   = op_r[IDX_W-1:0];
  assign last_idx = (idx_r == IDX_W'(NUM_OPS - 1));
  assign ftot     = 20'(NUM_OPS) * {6'd0, pmin};
  assign span     = (ftot >= 20'd65536) ? 17'd0 : 17'(20'd65536 - ftot);
  assign qop      = q_r[op_idx];
  assign diff     = (rew_r >= qop) ? rew_r - qop : qop - rew_r;
  assign prod     = alpha * diff;
  assign start_idx = IDX_W'(({16'd0, in_random_draw} * 32'(NUM_OPS)) >> 16);
  assign cum_n    = cum_r + {16'd0, p_r[idx_r]};
  assign sel_q    = q_r[idx_r];
  assign rtry     = {drem_r[SUM_W-1:0], dnum_r[NUM_W-1]};

  always_comb begin
    if (mode) qnew = rew_r;
    else if (rew_r >= qop) qnew = qop + prod[31:16];
    else qnew = qop - prod[31:16];
  end

  always_comb begin
    if (sum_r == '0) pfull = {4'd0, pmin} + 18'(span / 17'(NUM_OPS));
    else pfull = {4'd0, pmin} + 18'(dquo_r);
  end

  // status
  always_comb begin
    sts.is_reward     = act_r;
    sts.op_valid      = ({1'b0, op_r} < 7'(NUM_OPS));
    sts.untried_phase = (rcnt_r < 32'(NUM_OPS));
    sts.scan_found    = !tried_r[idx_r];
    sts.scan_last     = (cnt_r == CNT_W'(NUM_OPS - 1));
    sts.roul_done     = last_idx || (cum_n > {16'd0, draw_r});
    sts.idx_last      = last_idx;
    sts.div_done      = (dcnt_r == '0);
    sts.lead_rescan   = (lead_r == op_r && q_r[op_idx] < lq_r) ||
                        (q_r[lead_r[IDX_W-1:0]] != lq_r);
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_OPS; i++) begin
        q_r[i] <= Q_ONE;
        p_r[i] <= P_INIT;
      end
      tried_r <= '0;
      rcnt_r  <= '0;
      xpl_r   <= '0;
      xpr_r   <= '0;
      lead_r  <= '0;
      lq_r    <= '0;
    end else begin
      if (cmd.load && in_action && ({1'b0, in_op_index} < 7'(NUM_OPS))) begin
        if (lead_r == in_op_index) xpl_r <= xpl_r + 32'd1;
        else xpr_r <= xpr_r + 32'd1;
      end
      if (cmd.qupd) begin
        q_r[op_idx]     <= qnew;
        tried_r[op_idx] <= 1'b1;
        if (rcnt_r != 32'hFFFF_FFFF) rcnt_r <= rcnt_r + 32'd1;
      end
      if (cmd.pwr) p_r[idx_r] <= (pfull > 18'd65535) ? 16'hFFFF : pfull[15:0];
      if (cmd.lead_fast && q_r[op_idx] >= lq_r) begin
        lead_r <= op_r;
        lq_r   <= q_r[op_idx];
      end
      if (cmd.commit && !cmd.lead_fast) begin
        lead_r <= (sel_q > nlq_r) ? OP_W'(idx_r) : nlead_r;
        lq_r   <= (sel_q > nlq_r) ? sel_q : nlq_r;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_action;
      op_r      <= in_op_index;
      rew_r     <= in_reward_value;
      draw_r    <= in_random_draw;
      idx_r     <= start_idx;
      cnt_r     <= '0;
      cum_r     <= '0;
      chosen_r  <= in_op_index;
      untried_r <= 1'b0;
      exploit_r <= in_action && (lead_r == in_op_index) &&
                   ({1'b0, in_op_index} < 7'(NUM_OPS));
    end
    if (cmd.scan_step) begin
      if (!tried_r[idx_r]) begin
        chosen_r  <= OP_W'(idx_r);
        untried_r <= 1'b1;
      end
      idx_r <= (last_idx) ? '0 : idx_r + IDX_W'(1);
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.roul_step) begin
      cum_r <= cum_n;
      chosen_r <= OP_W'(idx_r);
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.qupd) sum_r <= '0;
    if (cmd.sum_step) begin
      sum_r <= sum_r + SUM_W'(sel_q);
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.div_start) begin
      dnum_r <= {16'd0, span} * {17'd0, sel_q};
      dquo_r <= '0;
      drem_r <= '0;
      dcnt_r <= DC_W'(NUM_W);
    end
    if (cmd.div_step && dcnt_r != '0) begin
      dnum_r <= {dnum_r[NUM_W-2:0], 1'b0};
      if (rtry >= {1'b0, sum_r}) begin
        drem_r <= rtry - {1'b0, sum_r};
        dquo_r <= {dquo_r[NUM_W-2:0], 1'b1};
      end else begin
        drem_r <= rtry;
        dquo_r <= {dquo_r[NUM_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - DC_W'(1);
    end
    if (cmd.pwr) idx_r <= idx_r + IDX_W'(1);
    // leader rescan over the updated table
    if (cmd.lead_init) begin
      nlead_r <= '0;
      nlq_r   <= q_r[0];
      idx_r   <= IDX_W'(1);
    end
    if (cmd.lead_step) begin
      if (sel_q > nlq_r) begin
        nlead_r <= OP_W'(idx_r);
        nlq_r   <= sel_q;
      end
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.clr_idx && !cmd.lead_init) idx_r <= '0;
  end

  assign out_chosen_op    = chosen_r;
  assign out_from_untried = untried_r;
  assign out_leader_op    = lead_r;
  assign out_was_exploit  = exploit_r;

endmodule
`default_nettype wire

[rtl/probability_matching_selector.sv]
`default_nettype none
// channel | direction | ports
// input   | in        | in_valid, in_stall, in_action, in_op_index, in_reward_value,
//         |           | in_random_draw
// result  | out       | out_valid, out_stall, out_chosen_op, out_from_untried,
//         |           | out_leader_op, out_was_exploit
// config  | in        | cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr, cfg_pwdata
// one item at a time; a select uses the untried scan, then the roulette if none is found
// a reward updates the quality, sums the table and recomputes each probability, then may rescan the leader;
// the shared bit-serial divider serves every operator in turn (start, steps, done, write)
// synchronous active-low reset restores the tables; the result is held until not stalled
// the next item is taken once the result has left
module probability_matching_selector
  import pms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [5:0]  in_op_index,
  input  wire logic [15:0] in_reward_value,
  input  wire logic [15:0] in_random_draw,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_chosen_op,
  output logic             out_from_untried,
  output logic [5:0]       out_leader_op,
  output logic             out_was_exploit,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [13:0] pmin_r;
  logic [15:0] alpha_r;
  logic        mode_r;
  logic        wr_en;
  pms_cmd_t    cmd;
  pms_sts_t    sts;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmin_r  <= PMIN_RST;
      alpha_r <= ALPHA_RST;
      mode_r  <= 1'b0;
    end else if (wr_en && cfg_paddr[1:0] == 2'd0) begin
      unique case (cfg_paddr[3:2])
        REG_PMIN:  pmin_r  <= cfg_pwdata[13:0];
        REG_ALPHA: alpha_r <= cfg_pwdata[15:0];
        REG_MODE:  mode_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_PMIN:  cfg_prdata = {18'd0, pmin_r};
      REG_ALPHA: cfg_prdata = {16'd0, alpha_r};
      REG_MODE:  cfg_prdata = {31'd0, mode_r};
      default:   cfg_prdata = '0;
    endcase
  end

  pms_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  pms_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_action, .in_op_index, .in_reward_value,
    .in_random_draw, .pmin(pmin_r), .alpha(alpha_r), .mode(mode_r),
    .out_chosen_op, .out_from_untried, .out_leader_op, .out_was_exploit
  );

  // no new item taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("item taken with result pending");

  // an accepted item produces a busy cycle next
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("accept not followed by busy");

  // a result from the untried scan never reports exploit
  a_select_no_exploit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_from_untried |-> !out_was_exploit)
    else $error("exploit flag on select");

endmodule
`default_nettype wire

[verif/tb_top.sv]
`default_nettype none
module tb_top;
  import pms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_SELECT = 1'b0;
  localparam logic ACT_REWARD = 1'b1;
  localparam int   HOLD_CYCLES = 400;

  typedef struct packed {
    logic [5:0] chosen;
    logic       untried;
    logic [5:0] leader;
    logic       exploit;
  } pick_t;

  typedef struct {
    logic        act;
    logic [5:0]  op;
    logic [15:0] rew;
    logic [15:0] draw;
    bit          typed;
    pick_t       want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [5:0]  in_op_index = '0;
  logic [15:0] in_reward_value = '0;
  logic [15:0] in_random_draw = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_chosen_op;
  logic        out_from_untried;
  logic [5:0]  out_leader_op;
  logic        out_was_exploit;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  probability_matching_selector u_dut (.*);

  // shadow of the selector state
  logic [15:0] quality [NUM_OPS];
  logic [15:0] prob [NUM_OPS];
  bit          tried [NUM_OPS];
  int unsigned rewards_seen;
  int unsigned lead_op;
  logic [15:0] lead_q;
  int unsigned pmin_r;
  int unsigned alpha_r;
  bit          mode_r;

  pick_t pending_picks[$];
  int    errors = 0;
  bit    idle_en = 1'b1;
  bit    hold_req = 1'b0;
  int    hold_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void recompute_probs();
    longint unsigned sum, floor_total, span, share, p;
    sum = 0;
    floor_total = longint'(NUM_OPS) * pmin_r;
    span = (floor_total >= 65536) ? 0 : 65536 - floor_total;
    for (int i = 0; i < NUM_OPS; i++) sum += quality[i];
    for (int i = 0; i < NUM_OPS; i++) begin
      share = (sum == 0) ? span / NUM_OPS : (span * quality[i]) / sum;
      p = pmin_r + share;
      prob[i] = (p > 65535) ? 16'hFFFF : p[15:0];
    end
  endfunction

  function automatic void refresh_lead(int unsigned op);
    logic [15:0] q;
    bit any;
    q = quality[op];
    if ((lead_op == op && q < lead_q) || quality[lead_op] != lead_q) begin
      any = 1'b0;
      lead_op = 0;
      for (int i = 0; i < NUM_OPS; i++) begin
        if (!any || quality[i] > lead_q) begin
          lead_q = quality[i];
          lead_op = i;
          any = 1'b1;
        end
      end
    end else if (q >= lead_q) begin
      lead_op = op;
      lead_q = q;
    end
  endfunction

  // expected result of one item, updates the shadow state
  function automatic pick_t predict_pick(logic act, logic [5:0] op, logic [15:0] rew,
                                         logic [15:0] draw);
    pick_t r;
    int unsigned start, k, cum, q, d;
    bit found;
    r = '0;
    if (act == ACT_SELECT) begin
      found = 1'b0;
      if (rewards_seen < NUM_OPS) begin
        start = (32'(draw) * NUM_OPS) >> 16;
        for (int j = 0; j < NUM_OPS && !found; j++) begin
          k = (start + j) % NUM_OPS;
          if (!tried[k]) begin
            r.chosen = 6'(k);
            found = 1'b1;
          end
        end
      end
      if (found) begin
        r.untried = 1'b1;
      end else begin
        cum = 0;
        r.chosen = 6'(NUM_OPS - 1);
        for (int i = 0; i < NUM_OPS - 1; i++) begin
          cum += prob[i];
          if (cum > draw) begin
            r.chosen = 6'(i);
            break;
          end
        end
      end
    end else begin
      r.chosen = op;
      if (op < NUM_OPS) begin
        q = quality[op];
        if (lead_op == op) r.exploit = 1'b1;
        if (!mode_r) begin
          if (rew >= q) begin
            d = (longint'(alpha_r) * (rew - q)) >> 16;
            q += d;
          end else begin
            d = (longint'(alpha_r) * (q - rew)) >> 16;
            q -= d;
          end
        end else begin
          q = rew;
        end
        quality[op] = q[15:0];
        recompute_probs();
        refresh_lead(op);
        tried[op] = 1'b1;
        if (rewards_seen != 32'hFFFF_FFFF) rewards_seen++;
      end
    end
    r.leader = 6'(lead_op);
    return r;
  endfunction

  // offer one item, wait for acceptance, queue its expected result
  task automatic drive_item(logic act, logic [5:0] op, logic [15:0] rew, logic [15:0] draw,
                            bit typed, pick_t want);
    pick_t p;
    if (idle_en && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_op_index <= op;
    in_reward_value <= rew;
    in_random_draw <= draw;
    do @(posedge clk); while (in_stall);
    p = predict_pick(act, op, rew, draw);
    pending_picks.push_back(typed ? want : p);
  endtask

  task automatic rand_item();
    logic [5:0]  op;
    logic [15:0] rew;
    op = ($urandom_range(7) == 0) ? 6'($urandom_range(63, NUM_OPS)) : 6'($urandom_range(7));
    case ($urandom_range(7))
      0: rew = 16'h0000;
      1: rew = 16'hFFFF;
      2: rew = 16'($urandom_range(8192));
      default: rew = 16'($urandom);
    endcase
    drive_item(1'($urandom_range(1)), op, rew, 16'($urandom), 1'b0, '0);
  endtask

  // register write once the block is idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait (pending_picks.size() == 0);
    in_valid <= 1'b0;
    repeat (8) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_PMIN:  pmin_r = val[13:0];
      REG_ALPHA: alpha_r = val[15:0];
      REG_MODE:  mode_r = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int unsigned pmin, int unsigned alpha, bit mode);
    write_reg(REG_PMIN, pmin);
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_MODE, 32'(mode));
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < 17);
    end
  end

  // result checker
  always @(posedge clk) begin
    pick_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        $display("%0t: result with none expected: op %0d untried %0d leader %0d exploit %0d",
                 $time, out_chosen_op, out_from_untried, out_leader_op, out_was_exploit);
        errors++;
      end else begin
        e = pending_picks.pop_front();
        if (out_chosen_op !== e.chosen) begin
          $display("%0t: chosen_op expected %0d got %0d", $time, e.chosen, out_chosen_op);
          errors++;
        end
        if (out_from_untried !== e.untried) begin
          $display("%0t: from_untried expected %0d got %0d", $time, e.untried,
                   out_from_untried);
          errors++;
        end
        if (out_leader_op !== e.leader) begin
          $display("%0t: leader_op expected %0d got %0d", $time, e.leader, out_leader_op);
          errors++;
        end
        if (out_was_exploit !== e.exploit) begin
          $display("%0t: was_exploit expected %0d got %0d", $time, e.exploit,
                   out_was_exploit);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  stim_row_t directed_rows[] = '{
    '{ACT_SELECT, 6'd0,  16'h0000, 16'h0000, 1'b1, '{6'd0, 1'b1, 6'd0, 1'b0}},
    '{ACT_SELECT, 6'd63, 16'hFFFF, 16'hFFFF, 1'b1, '{6'd7, 1'b1, 6'd0, 1'b0}},
    '{ACT_REWARD, 6'd63, 16'hFFFF, 16'h0000, 1'b1, '{6'd63, 1'b0, 6'd0, 1'b0}},
    '{ACT_REWARD, 6'd8,  16'h0000, 16'hFFFF, 1'b1, '{6'd8, 1'b0, 6'd0, 1'b0}},
    '{ACT_REWARD, 6'd0,  16'hFFFF, 16'h0000, 1'b0, '0},
    '{ACT_SELECT, 6'd0,  16'h0000, 16'h0000, 1'b0, '0},
    '{ACT_REWARD, 6'd1,  16'h0000, 16'h0000, 1'b0, '0},
    '{ACT_REWARD, 6'd7,  16'h1000, 16'h0000, 1'b0, '0},
    '{ACT_SELECT, 6'd0,  16'h0000, 16'h8000, 1'b0, '0},
    '{ACT_REWARD, 6'd2,  16'h04D2, 16'h0000, 1'b0, '0},
    '{ACT_REWARD, 6'd3,  16'hFFFF, 16'h0000, 1'b0, '0},
    '{ACT_REWARD, 6'd4,  16'h0000, 16'h0000, 1'b0, '0},
    '{ACT_REWARD, 6'd5,  16'h8000, 16'h0000, 1'b0, '0},
    '{ACT_SELECT, 6'd0,  16'h0000, 16'hC000, 1'b0, '0},
    '{ACT_REWARD, 6'd6,  16'h1000, 16'h0000, 1'b0, '0},
    '{ACT_SELECT, 6'd0,  16'h0000, 16'h0000, 1'b0, '0},
    '{ACT_SELECT, 6'd0,  16'h0000, 16'hFFFF, 1'b0, '0},
    '{ACT_SELECT, 6'd0,  16'h0000, 16'h7FFF, 1'b0, '0},
    '{ACT_SELECT, 6'd0,  16'h0000, 16'h0001, 1'b0, '0},
    '{ACT_REWARD, 6'd3,  16'h0000, 16'h0000, 1'b0, '0},
    '{ACT_REWARD, 6'd0,  16'h0000, 16'h0000, 1'b0, '0},
    '{ACT_SELECT, 6'd0,  16'h0000, 16'h4000, 1'b0, '0}
  };

  initial begin
    for (int i = 0; i < NUM_OPS; i++) begin
      quality[i] = Q_ONE;
      prob[i] = P_INIT;
      tried[i] = 1'b0;
    end
    rewards_seen = 0;
    lead_op = 0;
    lead_q = '0;
    pmin_r = PMIN_RST;
    alpha_r = ALPHA_RST;
    mode_r = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items under reset settings
    foreach (directed_rows[i])
      drive_item(directed_rows[i].act, directed_rows[i].op, directed_rows[i].rew,
                 directed_rows[i].draw, directed_rows[i].typed, directed_rows[i].want);

    // replace mode with zero rewards everywhere gives a zero quality sum
    apply_setting(1000, 65535, 1'b1);
    for (int i = 0; i < NUM_OPS; i++) drive_item(ACT_REWARD, 6'(i), 16'h0000, '0, 1'b0, '0);
    drive_item(ACT_SELECT, 6'd0, '0, 16'h0000, 1'b0, '0);
    drive_item(ACT_SELECT, 6'd0, '0, 16'hFFFF, 1'b0, '0);

    // random items across several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_setting(0, 0, 1'b0);
        1: apply_setting(8192, 65535, 1'b0);
        2: apply_setting(8191, 1, 1'b1);
        3: apply_setting(0, 65535, 1'b1);
        4: apply_setting($urandom_range(8192), $urandom_range(65535), 1'($urandom_range(1)));
        default: apply_setting(PMIN_RST, ALPHA_RST, 1'b0);
      endcase
      idle_en = (ph != 2);
      for (int n = 0; n < 63; n++) begin
        if (ph == 4 && n == 10) hold_req = 1'b1;
        rand_item();
      end
      in_valid <= 1'b0;
      idle_en = 1'b1;
    end

    in_valid <= 1'b0;
    wait (pending_picks.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_picks.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

[probability_matching_selector.f]
rtl/pms_pkg.sv
rtl/pms_ctrl.sv
rtl/pms_dp.sv
rtl/probability_matching_selector.sv
verif/tb_top.sv
